>>> rtl/rpv_pkg.sv
package rpv_pkg;

    // input point, signed q16.8
    typedef struct packed {
        logic signed [23:0] point_x;
        logic signed [23:0] point_y;
        logic signed [23:0] point_z;
    } point_t;

    // projected result
    typedef struct packed {
        logic signed [15:0] pixel_x;
        logic signed [15:0] pixel_y;
        logic signed [23:0] view_depth;
        logic               behind_camera;
    } result_t;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_ROT_X    = 2'd0,
        REG_ROT_Y    = 2'd1,
        REG_CENTER_X = 2'd2,
        REG_CENTER_Y = 2'd3
    } reg_index_t;

    // quarter-wave sine polynomial
    localparam int SIN_A   = 51472;
    localparam int SIN_B   = 21024;
    localparam int SIN_C   = 2320;
    localparam int QUARTER = 16384;

    // projection constants
    localparam int DEPTH_BIAS   = 64000;
    localparam int OFFSET_SCALE = 250;

    // pipeline depth figures
    localparam int TRIG_SETTLE = 5;
    localparam int QUOT_W      = 18;
    localparam int DIV_BITS    = 2;
    localparam int DIV_STAGES  = QUOT_W / DIV_BITS;
    localparam int PRE_STAGES  = 5;
    localparam int NUM_STAGES  = PRE_STAGES + DIV_STAGES + 1;

    // divider widths: remainder, denominator, compare
    localparam int RW = 36;
    localparam int DW = 28;
    localparam int CW = 46;

endpackage

>>> rtl/rotate_project_vertex.sv
// channel   | signals                        | payload
// ----------+--------------------------------+-------------------------
// in        | in_valid / in_ready            | in_data (point_t)
// out       | out_valid / out_ready          | out_data (result_t)
// cfg       | cfg_we, cfg_index              | cfg_data (16 bit)
//
// one point per cycle while in_ready is high; 5 rotate/setup stages, 9 divider
// stages of 2 quotient bits each, 1 output stage
// sine/cosine come from a 4-stage polynomial pipeline: in_ready drops
// after reset and after each register write while it settles
// the whole pipeline holds when the output register is full and not taken
module rotate_project_vertex (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  rpv_pkg::point_t       in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output rpv_pkg::result_t      out_data,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [15:0]           cfg_data
);
    import rpv_pkg::*;

    // configuration registers
    logic [15:0]        rot_x_reg, rot_y_reg;
    logic signed [15:0] origin_x_reg, origin_y_reg;
    logic [2:0]         settle_reg, settle_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rot_x_reg    <= '0;
            rot_y_reg    <= '0;
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            settle_reg   <= 3'(TRIG_SETTLE);
        end
        else
        begin
            settle_reg <= settle_next;
            if (cfg_we)
            begin
                case (reg_index_t'(cfg_index))
                    REG_ROT_X:    rot_x_reg    <= cfg_data;
                    REG_ROT_Y:    rot_y_reg    <= cfg_data;
                    REG_CENTER_X: origin_x_reg <= cfg_data;
                    REG_CENTER_Y: origin_y_reg <= cfg_data;
                    default:      ;
                endcase
            end
        end
    end

    // settle count for the trig pipeline
    always_comb
    begin
        if (cfg_we)
            settle_next = 3'(TRIG_SETTLE);
        else if (settle_reg != '0)
            settle_next = settle_reg - 3'd1;
        else
            settle_next = settle_reg;
    end

    // trig lanes: 0 sin x, 1 cos x, 2 sin y, 3 cos y
    logic [14:0]        t_in [4];
    logic               neg_in [4];
    logic [14:0]        ta_reg [4], tb_reg [4], tc_reg [4];
    logic               na_reg [4], nb_reg [4], nc_reg [4];
    logic [14:0]        t2a_reg [4], t2b_reg [4];
    logic [11:0]        inner_reg [4];
    logic [14:0]        mid_reg [4];
    logic signed [16:0] trig_reg [4];

    always_comb
    begin
        logic [15:0] ang;
        ang = '0;
        for (int l = 0; l < 4; l++)
        begin
            ang = (l < 2) ? rot_x_reg : rot_y_reg;
            if (l % 2 == 1)
                ang = ang + 16'(QUARTER);
            t_in[l]   = ang[14] ? 15'(QUARTER) - {1'b0, ang[13:0]} : {1'b0, ang[13:0]};
            neg_in[l] = ang[15];
        end
    end

    // quarter sine polynomial, one product per stage
    always_ff @(posedge clk)
    begin
        logic [29:0] sq;
        logic [26:0] pi;
        logic [29:0] pm;
        logic [30:0] ps;
        for (int l = 0; l < 4; l++)
        begin
            sq = {15'd0, t_in[l]} * {15'd0, t_in[l]};
            ta_reg[l]  <= t_in[l];
            na_reg[l]  <= neg_in[l];
            t2a_reg[l] <= sq[28:14];

            pi = 27'(SIN_C) * {12'd0, t2a_reg[l]};
            inner_reg[l] <= pi[25:14];
            t2b_reg[l]   <= t2a_reg[l];
            tb_reg[l]    <= ta_reg[l];
            nb_reg[l]    <= na_reg[l];

            pm = (30'(SIN_B) - {18'd0, inner_reg[l]}) * {15'd0, t2b_reg[l]};
            mid_reg[l] <= pm[28:14];
            tc_reg[l]  <= tb_reg[l];
            nc_reg[l]  <= nb_reg[l];

            ps = (31'(SIN_A) - {16'd0, mid_reg[l]}) * {16'd0, tc_reg[l]};
            trig_reg[l] <= nc_reg[l] ? -$signed({1'b0, ps[29:14]})
                                     : $signed({1'b0, ps[29:14]});
        end
    end

    // pipeline control
    logic [NUM_STAGES-1:0] vld_reg;
    logic                  adv;

    assign adv      = !vld_reg[NUM_STAGES-1] || out_ready;
    assign in_ready = adv && (settle_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[NUM_STAGES-2:0], in_valid && in_ready};
    end

    // datapath registers
    logic signed [23:0] x1_reg, x2p_reg;
    logic signed [40:0] m_ycx_reg, m_zsx_reg, m_ysx_reg, m_zcx_reg;
    logic signed [26:0] y1_reg, y1b_reg;
    logic signed [26:0] z1_reg;
    logic signed [43:0] m_xcy_reg, m_zsy_reg, m_zcy_reg, m_xsy_reg;
    logic signed [27:0] x2_reg, z2_reg;
    logic signed [26:0] y1c_reg;

    logic [RW-1:0]      rx_reg [DIV_STAGES];
    logic [RW-1:0]      ry_reg [DIV_STAGES];
    logic [QUOT_W-1:0]  qx_reg [DIV_STAGES+1];
    logic [QUOT_W-1:0]  qy_reg [DIV_STAGES+1];
    logic [DW-1:0]      den_reg [DIV_STAGES];
    logic               sx_reg [DIV_STAGES+1];
    logic               sy_reg [DIV_STAGES+1];
    logic               ox_reg [DIV_STAGES+1];
    logic               oy_reg [DIV_STAGES+1];
    logic               bh_reg [DIV_STAGES+1];
    logic signed [23:0] dep_reg [DIV_STAGES+1];

    result_t            out_reg;

    // one restoring division step: {quotient bit, remainder}
    function automatic logic [RW:0] div_step(input logic [RW-1:0] r,
                                             input logic [DW-1:0] d,
                                             input int sh);
        logic [CW-1:0] ds;
        logic [CW-1:0] rr;
        ds = CW'(d) << sh;
        rr = CW'(r);
        if (rr >= ds)
            return {1'b1, RW'(rr - ds)};
        return {1'b0, r};
    endfunction

    // stage 5 combinational setup
    logic signed [28:0] den_c;
    logic signed [36:0] nx_c, ny_c;
    logic [RW-1:0]      ax_c, ay_c;
    logic [CW-1:0]      lim_c;
    logic [DW-1:0]      dpos_c;
    logic signed [23:0] dep_c;

    always_comb
    begin
        den_c  = 29'(DEPTH_BIAS) + 29'(z2_reg);
        dpos_c = (den_c > 0) ? DW'(den_c) : DW'(1);
        nx_c   = 37'(x2_reg) * 37'(OFFSET_SCALE);
        ny_c   = 37'(y1c_reg) * 37'(OFFSET_SCALE);
        ax_c   = nx_c[36] ? RW'(-nx_c) : RW'(nx_c);
        ay_c   = ny_c[36] ? RW'(-ny_c) : RW'(ny_c);
        lim_c  = CW'(dpos_c) << QUOT_W;
        if (z2_reg > 28'sd8388607)
            dep_c = 24'sh7FFFFF;
        else if (z2_reg < -28'sd8388608)
            dep_c = 24'sh800000;
        else
            dep_c = 24'(z2_reg);
    end

    // output stage combinational
    logic [QUOT_W-1:0]     qcx_c, qcy_c;
    logic signed [19:0]    px_c, py_c;
    result_t               res_c;

    always_comb
    begin
        qcx_c = ox_reg[DIV_STAGES] ? '1 : qx_reg[DIV_STAGES];
        qcy_c = oy_reg[DIV_STAGES] ? '1 : qy_reg[DIV_STAGES];
        px_c  = 20'(origin_x_reg) + (sx_reg[DIV_STAGES] ? -$signed(20'(qcx_c))
                                                       : $signed(20'(qcx_c)));
        py_c  = 20'(origin_y_reg) - (sy_reg[DIV_STAGES] ? -$signed(20'(qcy_c))
                                                       : $signed(20'(qcy_c)));
        res_c.view_depth    = dep_reg[DIV_STAGES];
        res_c.behind_camera = bh_reg[DIV_STAGES];
        if (bh_reg[DIV_STAGES])
        begin
            res_c.pixel_x = '0;
            res_c.pixel_y = '0;
        end
        else
        begin
            res_c.pixel_x = (px_c > 20'sd32767) ? 16'sh7FFF :
                            (px_c < -20'sd32768) ? 16'sh8000 : 16'(px_c);
            res_c.pixel_y = (py_c > 20'sd32767) ? 16'sh7FFF :
                            (py_c < -20'sd32768) ? 16'sh8000 : 16'(py_c);
        end
    end

    // datapath, all stages advance together
    always_ff @(posedge clk)
    begin
        logic signed [41:0] sa, sb;
        logic signed [44:0] sc, sd;
        logic [RW:0]        stx, sty, stx2, sty2;
        int                 sh;
        if (adv)
        begin
            // stage 1: rotate about x, products
            x1_reg    <= in_data.point_x;
            m_ycx_reg <= 41'(in_data.point_y) * 41'(trig_reg[1]);
            m_zsx_reg <= 41'(in_data.point_z) * 41'(trig_reg[0]);
            m_ysx_reg <= 41'(in_data.point_y) * 41'(trig_reg[0]);
            m_zcx_reg <= 41'(in_data.point_z) * 41'(trig_reg[1]);

            // stage 2: round to q16.8
            sa = 42'(m_ycx_reg) - 42'(m_zsx_reg) + 42'sd16384;
            sb = 42'(m_ysx_reg) + 42'(m_zcx_reg) + 42'sd16384;
            y1_reg  <= sa[41:15];
            z1_reg  <= sb[41:15];
            x2p_reg <= x1_reg;

            // stage 3: rotate about y, products
            m_xcy_reg <= 44'(x2p_reg) * 44'(trig_reg[3]);
            m_zsy_reg <= 44'(z1_reg) * 44'(trig_reg[2]);
            m_zcy_reg <= 44'(z1_reg) * 44'(trig_reg[3]);
            m_xsy_reg <= 44'(x2p_reg) * 44'(trig_reg[2]);
            y1b_reg   <= y1_reg;

            // stage 4: round
            sc = 45'(m_xcy_reg) + 45'(m_zsy_reg) + 45'sd16384;
            sd = 45'(m_zcy_reg) - 45'(m_xsy_reg) + 45'sd16384;
            x2_reg  <= sc[42:15];
            z2_reg  <= sd[42:15];
            y1c_reg <= y1b_reg;

            // stage 5: divider setup
            rx_reg[0]  <= ax_c;
            ry_reg[0]  <= ay_c;
            qx_reg[0]  <= '0;
            qy_reg[0]  <= '0;
            den_reg[0] <= dpos_c;
            sx_reg[0]  <= nx_c[36];
            sy_reg[0]  <= ny_c[36];
            ox_reg[0]  <= CW'(ax_c) >= lim_c;
            oy_reg[0]  <= CW'(ay_c) >= lim_c;
            bh_reg[0]  <= den_c <= 0;
            dep_reg[0] <= dep_c;

            // divider stages, two quotient bits each
            for (int k = 1; k <= DIV_STAGES; k++)
            begin
                sh   = QUOT_W - DIV_BITS*(k-1) - 1;
                stx  = div_step(rx_reg[k-1], den_reg[k-1], sh);
                sty  = div_step(ry_reg[k-1], den_reg[k-1], sh);
                stx2 = div_step(stx[RW-1:0], den_reg[k-1], sh - 1);
                sty2 = div_step(sty[RW-1:0], den_reg[k-1], sh - 1);
                qx_reg[k] <= {qx_reg[k-1][QUOT_W-3:0], stx[RW], stx2[RW]};
                qy_reg[k] <= {qy_reg[k-1][QUOT_W-3:0], sty[RW], sty2[RW]};
                if (k < DIV_STAGES)
                begin
                    rx_reg[k]  <= stx2[RW-1:0];
                    ry_reg[k]  <= sty2[RW-1:0];
                    den_reg[k] <= den_reg[k-1];
                end
                sx_reg[k]  <= sx_reg[k-1];
                sy_reg[k]  <= sy_reg[k-1];
                ox_reg[k]  <= ox_reg[k-1];
                oy_reg[k]  <= oy_reg[k-1];
                bh_reg[k]  <= bh_reg[k-1];
                dep_reg[k] <= dep_reg[k-1];
            end

            // output register
            out_reg <= res_c;
        end
    end

    assign out_valid = vld_reg[NUM_STAGES-1];
    assign out_data  = out_reg;

`ifndef SYNTHESIS
    // behind the camera gives zero pixels
    a_behind_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.behind_camera |->
            out_data.pixel_x == '0 && out_data.pixel_y == '0)
        else $error("behind point with nonzero pixels");

    // behind the camera only for deep negative depth
    a_behind_depth: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.behind_camera |->
            out_data.view_depth <= -24'sd64000)
        else $error("behind flag with shallow depth");

    // no transfer while trig settles after a register write
    a_cfg_hold: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> !in_ready)
        else $error("input taken during trig settle");

    // pipeline holds while output is stalled
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(vld_reg))
        else $error("pipeline moved under stall");
`endif

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import rpv_pkg::*;

    localparam int STALL_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 40;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    point_t      in_data;
    logic        out_valid;
    logic        out_ready;
    result_t     out_data;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    rotate_project_vertex dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // projection settings mirrored from the register writes
    logic [15:0] angle_x;
    logic [15:0] angle_y;
    logic [15:0] origin_col;
    logic [15:0] origin_row;

    point_t  pending_points[$];
    result_t expected_pixels[$];
    int      errors;
    int      idle_cycles;
    int      hold_off;
    int      burst_left;
    int      gap_left;

    // clock
    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // quarter-wave polynomial sine, q15
    function automatic longint quarter_sine(longint t);
        longint t2;
        longint inner;
        longint mid;
        begin
            t2 = (t * t) >>> 14;
            inner = (SIN_C * t2) >>> 14;
            mid = ((SIN_B - inner) * t2) >>> 14;
            return ((SIN_A - mid) * t) >>> 14;
        end
    endfunction

    function automatic longint sine_q15(logic [15:0] a);
        longint s;
        begin
            if (a[14])
                s = quarter_sine(QUARTER - longint'(a[13:0]));
            else
                s = quarter_sine(longint'(a[13:0]));
            return a[15] ? -s : s;
        end
    endfunction

    // floor((v + 2^14) / 2^15)
    function automatic longint round_q15(longint v);
        return (v + 16384) >>> 15;
    endfunction

    function automatic longint clamp(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic result_t project_point(point_t p);
        longint cx, sx, cy, sy, y1, z1, x2, z2, den, px, py;
        result_t r;
        begin
            cx = sine_q15(angle_x + 16'd16384);
            sx = sine_q15(angle_x);
            cy = sine_q15(angle_y + 16'd16384);
            sy = sine_q15(angle_y);
            y1 = round_q15(longint'(p.point_y) * cx - longint'(p.point_z) * sx);
            z1 = round_q15(longint'(p.point_y) * sx + longint'(p.point_z) * cx);
            x2 = round_q15(longint'(p.point_x) * cy + z1 * sy);
            z2 = round_q15(z1 * cy - longint'(p.point_x) * sy);
            den = DEPTH_BIAS + z2;
            px = 0;
            py = 0;
            r.behind_camera = (den <= 0);
            if (den > 0)
            begin
                px = clamp(longint'($signed(origin_col)) + (x2 * OFFSET_SCALE) / den,
                           -32768, 32767);
                py = clamp(longint'($signed(origin_row)) - (y1 * OFFSET_SCALE) / den,
                           -32768, 32767);
            end
            r.pixel_x = px[15:0];
            r.pixel_y = py[15:0];
            r.view_depth = 24'(clamp(z2, -8388608, 8388607));
            return r;
        end
    endfunction

    function automatic logic signed [23:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 24'sh7FFFFF;
            1: return 24'sh800000;
            2: return 24'($urandom);
            default: return $signed(24'($urandom_range(0, 40000))) - 24'sd20000;
        endcase
    endfunction

    // driver: bursts with random gaps, prediction at each transfer
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data <= '0;
            burst_left <= 0;
            gap_left <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                expected_pixels.push_back(project_point(in_data));
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0 || pending_points.size() == 0)
                begin
                    in_valid <= 1'b0;
                    if (gap_left > 0)
                        gap_left <= gap_left - 1;
                end
                else
                begin
                    in_valid <= 1'b1;
                    in_data <= pending_points.pop_front();
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 30);
                        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
            end
        end
    end

    // monitor: compare each result transfer, receiver stall pattern
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            idle_cycles <= 0;
        end
        else
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (out_valid && out_ready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    $display("%0t unexpected result transfer: expected none actual %h",
                             $time, out_data);
                    errors <= errors + 1;
                end
                else
                begin
                    result_t exp_r;
                    exp_r = expected_pixels.pop_front();
                    if (exp_r.pixel_x !== out_data.pixel_x)
                        $display("%0t pixel_x expected %0d actual %0d", $time,
                                 exp_r.pixel_x, out_data.pixel_x);
                    if (exp_r.pixel_y !== out_data.pixel_y)
                        $display("%0t pixel_y expected %0d actual %0d", $time,
                                 exp_r.pixel_y, out_data.pixel_y);
                    if (exp_r.view_depth !== out_data.view_depth)
                        $display("%0t view_depth expected %0d actual %0d", $time,
                                 exp_r.view_depth, out_data.view_depth);
                    if (exp_r.behind_camera !== out_data.behind_camera)
                        $display("%0t behind_camera expected %0b actual %0b", $time,
                                 exp_r.behind_camera, out_data.behind_camera);
                    if (exp_r !== out_data)
                        errors <= errors + 1;
                end
            end
            if (hold_off > 0)
            begin
                out_ready <= 1'b0;
                hold_off <= hold_off - 1;
            end
            else if (($time / 400) % 3 == 0)
                out_ready <= 1'b1;
            else
                out_ready <= ($urandom_range(0, 3) != 0);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic write_reg(reg_index_t idx, logic [15:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        case (idx)
            REG_ROT_X:    angle_x = value;
            REG_ROT_Y:    angle_y = value;
            REG_CENTER_X: origin_col = value;
            REG_CENTER_Y: origin_row = value;
            default:      ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_points.size() != 0 || in_valid || expected_pixels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic queue_point(logic signed [23:0] x, logic signed [23:0] y,
                               logic signed [23:0] z);
        point_t p;
        p.point_x = x;
        p.point_y = y;
        p.point_z = z;
        pending_points.push_back(p);
    endtask

    initial
    begin
        errors = 0;
        hold_off = 0;
        angle_x = '0;
        angle_y = '0;
        origin_col = '0;
        origin_row = '0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_ROT_X;
        cfg_data = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed points at reset settings: extremes, behind camera, saturation
        queue_point(0, 0, 0);
        queue_point(24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF);
        queue_point(24'sh800000, 24'sh800000, 24'sh800000);
        queue_point(24'sh7FFFFF, 24'sh800000, 0);
        queue_point(256, 256, -24'sd64000);
        queue_point(256, 256, -24'sd63999);
        queue_point(256, 256, -24'sd64001);
        queue_point(24'sh7FFFFF, 24'sh800000, -24'sd63990);
        queue_point(24'sh555555, 24'shAAAAAA, 24'sh0F0F0F);
        wait_drained();

        // extremes of every register
        write_reg(REG_ROT_X, 16'hFFFF);
        write_reg(REG_ROT_Y, 16'h4000);
        write_reg(REG_CENTER_X, 16'h7FFF);
        write_reg(REG_CENTER_Y, 16'h8000);
        queue_point(24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF);
        queue_point(24'sh800000, 24'sh7FFFFF, -24'sd70000);
        queue_point(1000, -1000, 500);
        queue_point(24'sh7FFFFF, 24'sh7FFFFF, 24'sh800000);
        wait_drained();
        write_reg(REG_ROT_X, 16'h8000);
        write_reg(REG_ROT_Y, 16'hC000);
        write_reg(REG_CENTER_X, 16'h8000);
        write_reg(REG_CENTER_Y, 16'h7FFF);
        queue_point(24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF);
        queue_point(-5000, 7000, 100000);
        queue_point(24'sh800000, 24'sh800000, 24'sh7FFFFF);
        wait_drained();

        // random phases with random settings; the first one holds the receiver off
        for (int phase = 0; phase < 10; phase++)
        begin
            write_reg(REG_ROT_X, 16'($urandom));
            write_reg(REG_ROT_Y, 16'($urandom));
            write_reg(REG_CENTER_X, 16'($urandom_range(0, 3) == 0 ? $urandom
                                                               : $urandom_range(0, 640)));
            write_reg(REG_CENTER_Y, 16'($urandom_range(0, 3) == 0 ? $urandom
                                                               : $urandom_range(0, 480)));
            if (phase == 0)
                hold_off = 300;
            for (int i = 0; i < 85; i++)
                queue_point(rand_coord(), rand_coord(), rand_coord());
            wait_drained();
        end

        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

>>> rotate_project_vertex.f
rtl/rpv_pkg.sv
rtl/rotate_project_vertex.sv
tb/testbench.sv
